FILE: rtl/vamm_pkg.sv
// Shared types and constants for the vote aggregator (min, max, trigger).
// Used by vamm_ctrl, vamm_dpath and vote_aggregator_min_max_trigger_unit.
package vamm_pkg;

    // Number of voter slots in the vote table
    localparam int MAX_VOTERS = 16;

    // Combine modes; the unused code behaves as minimum
    localparam logic [1:0] MODE_MIN     = 2'd0;
    localparam logic [1:0] MODE_MAX     = 2'd1;
    localparam logic [1:0] MODE_TRIGGER = 2'd2;

    // Configuration register indexes
    localparam logic REG_COMBINE_MODE  = 1'b0;
    localparam logic REG_ACTIVE_VOTERS = 1'b1;

    localparam int          CFG_W          = 5;
    localparam logic [4:0]  VOTERS_RESET   = 5'd16;
    localparam logic [4:0]  WINNER_NONE    = 5'h1F;

    typedef struct packed {
        logic [7:0]         voter_index;
        logic signed [31:0] vote_value;
    } t_in;

    typedef struct packed {
        logic signed [4:0]  winner_index;
        logic signed [31:0] winner_value;
        logic               result_changed;
        logic               status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch the incoming transaction, read its slot
        logic write;       // store the adjusted vote
        logic scan_start;  // clear the running winner, rewind the slot counter
        logic scan_step;   // read one slot, judge the previous one
        logic finish;      // commit the scan result
        logic emit;        // hand the result to the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bad;         // voter index out of range
        logic same;        // vote equals the stored one
        logic scan_done;   // every slot in use has been judged
    } t_sts;

endpackage

FILE: rtl/vamm_ctrl.sv
// Controller state machine of the vote aggregator.
// Depends on vamm_pkg; drives vamm_dpath through t_cmd and reads t_sts.
module vamm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    input  vamm_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output vamm_pkg::t_cmd o_cmd
);
    import vamm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad || i_sts.same) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.write      = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A changed vote always goes on to a scan
    a_write_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |=> r_state == S_SCAN)
        else $error("vote write not followed by a scan");

    // A finished scan always leads to a pending result
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_done) |=> r_state == S_DONE)
        else $error("scan completion lost");

    // Take input transactions only while idle
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_state == S_IDLE)
        else $error("input taken outside idle");

endmodule

FILE: rtl/vamm_dpath.sv
// Datapath of the vote aggregator: configuration, vote table memory,
// slot scan and stored winner. Depends on vamm_pkg; commanded by vamm_ctrl.
module vamm_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_index,
    input  logic [vamm_pkg::CFG_W-1:0] i_cfg_data,
    input  vamm_pkg::t_in              i_in,
    input  vamm_pkg::t_cmd             i_cmd,
    output vamm_pkg::t_sts             o_sts,
    output vamm_pkg::t_out             o_res
);
    import vamm_pkg::*;

    localparam int IW = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
    localparam int CW = $clog2(MAX_VOTERS + 1);
    localparam logic [6:0] MAXV = 7'(MAX_VOTERS);

    // Configuration
    logic [1:0] r_mode;
    logic [4:0] r_active;

    // Vote table and its valid bits
    logic signed [31:0]    r_mem [MAX_VOTERS];
    logic [MAX_VOTERS-1:0] r_valid;
    logic signed [31:0]    r_rd_data;
    logic                  r_rd_vld;

    // Transaction
    logic [IW-1:0]      r_idx;
    logic signed [31:0] r_vote;
    logic               r_bad;
    logic               r_changed;

    // Scan
    logic [CW-1:0]      r_cnt;
    logic               r_eval;
    logic [IW-1:0]      r_eval_slot;
    logic               r_none;
    logic [IW-1:0]      r_win;
    logic signed [31:0] r_best;

    // Stored winner
    logic               r_cur_none;
    logic [IW-1:0]      r_cur_idx;
    logic signed [31:0] r_cur_val;

    logic               trig;
    logic               want_max;
    logic signed [31:0] withdrawn;
    logic [6:0]         slots;
    logic               in_bad;
    logic signed [31:0] adj_vote;
    logic signed [31:0] entry;
    logic               take;
    logic               issue;
    logic [IW-1:0]      rd_addr;
    logic signed [31:0] fin_val;
    logic               fin_changed;

    assign trig      = (r_mode == MODE_TRIGGER);
    assign want_max  = (r_mode == MODE_MAX);
    assign withdrawn = trig ? 32'sd0 : -32'sd1;

    // Saturate the slot count at the table depth
    assign slots  = ({2'b00, r_active} > MAXV) ? MAXV : {2'b00, r_active};
    assign in_bad = i_in.voter_index >= {1'b0, slots};

    // Clamp the vote to the stored form of the current mode
    always_comb begin
        if (trig) begin
            adj_vote = (i_in.vote_value > 32'sd0) ? 32'sd1 : 32'sd0;
        end else begin
            adj_vote = (i_in.vote_value < 32'sd0) ? -32'sd1 : i_in.vote_value;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MIN;
            r_active <= VOTERS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COMBINE_MODE:  r_mode   <= i_cfg_data[1:0];
                REG_ACTIVE_VOTERS: r_active <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Entry valid bits: an invalid slot reads as withdrawn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cfg_wr_en && i_cfg_index == REG_COMBINE_MODE) begin
            r_valid <= '0;
        end else if (i_cmd.write) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    // Table memory: one write port, one registered read port
    assign issue   = i_cmd.scan_step && ({{(7 - CW){1'b0}}, r_cnt} < slots);
    assign rd_addr = i_cmd.load ? i_in.voter_index[IW-1:0] : r_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_idx] <= r_vote;
        end
        if (i_cmd.load || issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
    end

    // Latch the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_in.voter_index[IW-1:0];
            r_vote <= adj_vote;
            r_bad  <= in_bad;
        end
    end

    assign entry = r_rd_vld ? r_rd_data : withdrawn;

    // Judge one slot against the running winner
    always_comb begin
        if (trig) begin
            take = r_none && (entry > 32'sd0);
        end else begin
            take = (entry >= 32'sd0) &&
                   (r_none || (want_max ? (entry > r_best) : (entry < r_best)));
        end
    end

    // Scan: read slot r_cnt, judge the slot read on the previous step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_eval <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_eval <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_cnt  <= '0;
            r_none <= 1'b1;
        end else if (i_cmd.scan_step) begin
            if (issue) begin
                r_cnt       <= r_cnt + 1'b1;
                r_eval_slot <= r_cnt[IW-1:0];
            end
            if (r_eval && take) begin
                r_none <= 1'b0;
                r_win  <= r_eval_slot;
                r_best <= entry;
            end
        end
    end

    // Compare the scan result with the stored winner
    assign fin_val     = r_none ? withdrawn : r_best;
    assign fin_changed = (r_none != r_cur_none) ||
                         (!r_none && r_win != r_cur_idx) ||
                         (fin_val != r_cur_val);

    // Stored winner; a mode write withdraws everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_none <= 1'b1;
            r_cur_val  <= -32'sd1;
            r_changed  <= 1'b0;
        end else if (i_cfg_wr_en && i_cfg_index == REG_COMBINE_MODE) begin
            r_cur_none <= 1'b1;
            r_cur_val  <= (i_cfg_data[1:0] == MODE_TRIGGER) ? 32'sd0 : -32'sd1;
        end else if (i_cmd.finish) begin
            r_cur_none <= r_none;
            r_cur_idx  <= r_win;
            r_cur_val  <= fin_val;
            r_changed  <= fin_changed;
        end else if (i_cmd.emit) begin
            r_changed  <= 1'b0;
        end
    end

    assign o_sts.bad       = r_bad;
    assign o_sts.same      = (entry == r_vote);
    assign o_sts.scan_done = !r_eval && ({{(7 - CW){1'b0}}, r_cnt} >= slots);

    assign o_res.winner_index   = r_cur_none ? WINNER_NONE : 5'(r_cur_idx);
    assign o_res.winner_value   = r_cur_val;
    assign o_res.result_changed = r_changed;
    assign o_res.status         = r_bad;

    // A trigger winner always holds one
    a_trig_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (trig && !r_cur_none) |-> r_cur_val == 32'sd1)
        else $error("trigger winner without a set trigger");

    // No winner in minimum or maximum mode reads as withdrawn
    a_none_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!trig && r_cur_none) |-> r_cur_val == -32'sd1)
        else $error("empty min/max result not withdrawn");

    // A winner slot lies inside the table
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_none |-> {{(7 - IW){1'b0}}, r_cur_idx} < MAXV)
        else $error("winner slot beyond table");

endmodule

FILE: rtl/vote_aggregator_min_max_trigger_unit.sv
// Top level of the vote aggregator: output register and the two halves.
// Depends on vamm_pkg, vamm_ctrl and vamm_dpath.
//
// Each transaction casts one vote for one slot and returns one result with the
// active slot, the active value, a change flag and a range status. A vote that
// is out of range or equal to the stored vote skips the scan and goes straight to
// its result; any other vote rescans the slots in use through the single read
// port of the vote table memory, one slot per cycle, before its result follows.
// One vote is in work at a time and the next one is taken the cycle after the
// result is handed on. The finished result waits in an output register, so the
// next vote is taken while the previous result is still stalled. No clearing
// pass is needed after reset or a mode write: per-slot valid bits make every
// unwritten slot read as withdrawn.
module vote_aggregator_min_max_trigger_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_index,
    input  logic [vamm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  vamm_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output vamm_pkg::t_out             o_out_data
);
    import vamm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_out res;
    logic out_free;
    logic r_out_valid;
    t_out r_out_data;

    // Output slot can take a result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    vamm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    vamm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (res)
    );

    // Hold the result transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: tb/vote_aggregator_min_max_trigger_unit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the vote aggregator: watches configuration, vote and result
// transactions, predicts each result and compares it. Depends on vamm_pkg.
module vote_aggregator_min_max_trigger_unit_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_index,
    input  logic [vamm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  vamm_pkg::t_in              i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  vamm_pkg::t_out             i_out_data,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    import vamm_pkg::*;

    // Predicted copy of the block's state and registers
    logic signed [31:0] ballot [MAX_VOTERS];
    int                 lead_slot;
    logic signed [31:0] lead_value;
    logic [1:0]         mode_reg;
    logic [4:0]         voters_reg;

    t_out awaited_results [$];
    int   fail_total  = 0;
    int   outstanding = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = outstanding;

    // Reset every slot to the withdrawn value of the current mode
    function automatic void clear_ballots();
        logic signed [31:0] withdrawn;
        withdrawn = (mode_reg == MODE_TRIGGER) ? 32'sd0 : -32'sd1;
        for (int i = 0; i < MAX_VOTERS; i++) ballot[i] = withdrawn;
        lead_slot  = -1;
        lead_value = withdrawn;
    endfunction

    // Apply one vote to the table and return the result it produces
    function automatic t_out tally_vote(t_in item);
        int                 slots;
        int                 win;
        logic signed [31:0] v;
        logic signed [31:0] val;
        logic               want_max;
        t_out               r;
        slots = (voters_reg > MAX_VOTERS) ? MAX_VOTERS : int'(voters_reg);
        r.status         = 1'b0;
        r.result_changed = 1'b0;
        if (int'(item.voter_index) >= slots) begin
            r.status = 1'b1;
        end else begin
            v = item.vote_value;
            if (mode_reg == MODE_TRIGGER) begin
                v = (v > 0) ? 32'sd1 : 32'sd0;
            end else if (v < 0) begin
                v = -32'sd1;
            end
            // A repeated vote leaves the aggregate untouched
            if (ballot[item.voter_index] != v) begin
                ballot[item.voter_index] = v;
                win = -1;
                if (mode_reg == MODE_TRIGGER) begin
                    for (int i = 0; i < slots; i++) begin
                        if (win < 0 && ballot[i] > 0) win = i;
                    end
                    val = (win < 0) ? 32'sd0 : ballot[win];
                end else begin
                    // The unused mode code falls through to minimum
                    want_max = (mode_reg == MODE_MAX);
                    for (int i = 0; i < slots; i++) begin
                        if (ballot[i] >= 0 && (win < 0 ||
                                (want_max ? ballot[i] > ballot[win]
                                          : ballot[i] < ballot[win]))) begin
                            win = i;
                        end
                    end
                    val = (win < 0) ? -32'sd1 : ballot[win];
                end
                r.result_changed = (win != lead_slot) || (val != lead_value);
                lead_slot  = win;
                lead_value = val;
            end
        end
        r.winner_index = lead_slot[4:0];
        r.winner_value = lead_value;
        return r;
    endfunction

    // Track transactions at each edge: results first, then writes, then votes
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            mode_reg   = MODE_MIN;
            voters_reg = VOTERS_RESET;
            clear_ballots();
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no vote outstanding: %p", i_out_data);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.winner_index !== want.winner_index) begin
                        $error("winner_index: expected %0d, actual %0d",
                               want.winner_index, i_out_data.winner_index);
                        fail_total++;
                    end
                    if (i_out_data.winner_value !== want.winner_value) begin
                        $error("winner_value: expected %0d, actual %0d",
                               want.winner_value, i_out_data.winner_value);
                        fail_total++;
                    end
                    if (i_out_data.result_changed !== want.result_changed) begin
                        $error("result_changed: expected %0d, actual %0d",
                               want.result_changed, i_out_data.result_changed);
                        fail_total++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_data.status);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_COMBINE_MODE) begin
                    mode_reg = i_cfg_data[1:0];
                    clear_ballots();
                end else begin
                    voters_reg = i_cfg_data[4:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(tally_vote(i_in_data));
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: tb/vote_aggregator_min_max_trigger_unit_tb.sv
`timescale 1ns / 1ps
// Top of the vote aggregator testbench: clock, reset, vote and register
// stimulus, result back-pressure and the verdict. Depends on vamm_pkg and the checker.
module vote_aggregator_min_max_trigger_unit_tb;
    import vamm_pkg::*;

    localparam int                 VOTE_TARGET    = 1300;
    localparam int                 HOLD_CYCLES    = 300;
    localparam int                 CYCLE_LIMIT    = 600000;
    localparam int                 DRAIN_CYCLES   = 25;
    localparam logic [1:0]         MODE_ALIAS_MIN = 2'd3;
    localparam logic signed [31:0] BALLOT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BALLOT_MIN     = 32'sh8000_0000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_index = REG_COMBINE_MODE;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;

    int fail_total;
    int outstanding;
    int cycle_count = 0;
    int stim_slots  = MAX_VOTERS;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    vote_aggregator_min_max_trigger_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    vote_aggregator_min_max_trigger_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_fail_count  (fail_total),
        .o_outstanding (outstanding)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Give up on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result back-pressure: random stall bursts, plus one long hold-off
    initial begin
        int hold_count;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one vote, with an optional gap first; return at its acceptance edge
    task automatic send_vote(input logic [7:0] slot, input logic [31:0] value);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {slot, value};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Write a register once every outstanding result has come back
    task automatic write_reg(input logic reg_idx, input logic [CFG_W-1:0] data);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (reg_idx == REG_ACTIVE_VOTERS) begin
            stim_slots = (int'(data) > MAX_VOTERS) ? MAX_VOTERS : int'(data);
        end
    endtask

    initial begin
        int          votes_cast;
        int          phase;
        logic [7:0]  slot;
        logic [31:0] value;
        logic [1:0]  mode_pick;
        logic [4:0]  voters_pick;

        votes_cast = 0;
        phase      = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Minimum mode: ties, repeats, range errors, maximal vote winning
        send_vote(8'd0, 32'd5);
        send_vote(8'd1, 32'd5);
        send_vote(8'd2, 32'd0);
        send_vote(8'd2, 32'd0);
        send_vote(8'd15, BALLOT_MAX);
        send_vote(8'd2, BALLOT_MIN);
        send_vote(8'd16, 32'd7);
        send_vote(8'd255, 32'hFFFF_FFFF);
        send_vote(8'd0, -32'sd5);
        send_vote(8'd1, -32'sd1);
        send_vote(8'd15, -32'sd1);

        // Maximum mode: tie on the largest value goes to the lower slot
        write_reg(REG_COMBINE_MODE, {3'd0, MODE_MAX});
        send_vote(8'd3, 32'd100);
        send_vote(8'd7, BALLOT_MAX);
        send_vote(8'd4, BALLOT_MAX);
        send_vote(8'd7, -32'sd7);

        // Trigger mode: clamped votes, then a lowered slot count
        write_reg(REG_COMBINE_MODE, {3'd0, MODE_TRIGGER});
        send_vote(8'd5, 32'd0);
        send_vote(8'd5, BALLOT_MIN);
        send_vote(8'd9, 32'd7);
        send_vote(8'd2, 32'd1);
        write_reg(REG_ACTIVE_VOTERS, 5'd2);
        send_vote(8'd2, 32'd1);
        send_vote(8'd1, 32'd3);

        // Unused mode code, no slots in use, then a saturating slot count
        write_reg(REG_COMBINE_MODE, {3'd0, MODE_ALIAS_MIN});
        write_reg(REG_ACTIVE_VOTERS, 5'd0);
        send_vote(8'd0, 32'd4);
        write_reg(REG_ACTIVE_VOTERS, 5'd31);
        send_vote(8'd15, 32'd4);

        // Random phases: reconfigure, then a burst of votes
        while (votes_cast < VOTE_TARGET) begin
            phase++;
            idle_on = (votes_cast < VOTE_TARGET - 200) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) != 0) begin
                mode_pick = 2'($urandom_range(0, 3));
                write_reg(REG_COMBINE_MODE, {3'd0, mode_pick});
            end
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 9))
                    0:       voters_pick = 5'd0;
                    1:       voters_pick = 5'd16;
                    2:       voters_pick = 5'($urandom_range(17, 31));
                    3:       voters_pick = 5'd1;
                    default: voters_pick = 5'($urandom_range(1, 16));
                endcase
                write_reg(REG_ACTIVE_VOTERS, voters_pick);
            end
            if (phase == 4) hold_req = 1'b1;
            repeat ($urandom_range(20, 80)) begin
                if (stim_slots == 0 || $urandom_range(0, 9) == 0) begin
                    slot = 8'($urandom_range(0, 255));
                end else begin
                    slot = 8'($urandom_range(0, stim_slots - 1));
                end
                // Small values make ties and repeats common
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: value = $urandom_range(0, 12);
                    4:          value = BALLOT_MAX;
                    5:          value = ($urandom_range(0, 1) != 0) ? BALLOT_MIN : 32'hFFFF_FFFF;
                    6:          value = $urandom | 32'h8000_0000;
                    default:    value = $urandom;
                endcase
                send_vote(slot, value);
                votes_cast++;
            end
        end

        // Drain outstanding results and let the block settle
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_total == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
